// ----- hw/rtl/cwaf_pkg.sv -----
// Shared types and constants for the crop window aspect fit unit.
package cwaf_pkg;

    localparam int MAX_DIM_DEF = 16384;
    localparam int CFG_W       = 15;
    localparam int MODE_W      = 3;
    localparam int COORD_W     = 16;
    localparam int OUT_XW      = 14;
    localparam int OUT_WW      = 15;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RATIO_MODE   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_4_3    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_16_9   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ORIG   = 3'd4;

    localparam logic                ACTION_DRAG  = 1'b0;
    localparam logic                ACTION_REFIT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT,
        S_D1,
        S_D1W,
        S_D2,
        S_D2W,
        S_CLAMP,
        S_ORG,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- hw/rtl/cwaf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module cwaf_div import cwaf_pkg::*; #(
    parameter int NW  = 33,
    parameter int DVW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic [NW-1:0]  o_quotient,
    output t_div_sts       o_sts
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_quo;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DVW:0]   w_trial;
    logic [DVW:0]   w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVW-1:0] : w_trial[DVW-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ----- hw/rtl/crop_window_aspect_fit_unit.sv -----
// Crop window aspect fit unit: drag/refit sequencer around a shared divider.
// Steps: fit; with a ratio, a rounded quotient for the width and, if it exceeds the
// image, another for the height (NW = 2*clog2(MAX_DIM+1)+1 bits, 31 at the default);
// then clamp, origin and output. The divider gives one bit a cycle. One beat at a
// time; a result not yet taken holds the next one at the output.
// Reset (synchronous, active low): image 1x1, free ratio, stored rectangle zero,
// inactive.
module crop_window_aspect_fit_unit import cwaf_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic signed [COORD_W-1:0] i_corner_a_x,
    input  logic signed [COORD_W-1:0] i_corner_a_y,
    input  logic signed [COORD_W-1:0] i_corner_b_x,
    input  logic signed [COORD_W-1:0] i_corner_b_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [OUT_XW-1:0]         o_rect_x,
    output logic [OUT_XW-1:0]         o_rect_y,
    output logic [OUT_WW-1:0]         o_rect_width,
    output logic [OUT_WW-1:0]         o_rect_height,
    output logic                      o_active
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int PW  = 2 * DW;
    localparam int NW  = 2 * DW + 1;
    localparam int DVW = DW + 1;
    localparam int EW  = (DW > CFG_W ? DW : CFG_W) + 1;
    localparam int SW  = (DW > COORD_W ? DW : COORD_W) + 2;

    // configuration
    logic [CFG_W-1:0]  r_iw_reg, r_ih_reg;
    logic [MODE_W-1:0] r_mode;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw_reg <= CFG_W'(1);
            r_ih_reg <= CFG_W'(1);
            r_mode   <= MODE_FREE;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  r_iw_reg <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_ih_reg <= pwdata[CFG_W-1:0];
                REG_RATIO_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_iw_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_ih_reg);
            REG_RATIO_MODE:   prdata = DATA_W'(r_mode);
            default:          prdata = '0;
        endcase
    end

    // effective image size
    logic [EW-1:0] w_iw_e, w_ih_e;
    logic [DW-1:0] w_iw, w_ih;

    always_comb begin
        w_iw_e = EW'(r_iw_reg);
        w_ih_e = EW'(r_ih_reg);
        if (w_iw_e == '0)              w_iw_e = EW'(1);
        else if (w_iw_e > EW'(MAX_DIM)) w_iw_e = EW'(MAX_DIM);
        if (w_ih_e == '0)              w_ih_e = EW'(1);
        else if (w_ih_e > EW'(MAX_DIM)) w_ih_e = EW'(MAX_DIM);
        w_iw = w_iw_e[DW-1:0];
        w_ih = w_ih_e[DW-1:0];
    end

    // ratio decode
    logic [DW-1:0] w_num, w_den;

    always_comb begin
        case (r_mode)
            MODE_SQUARE: begin w_num = DW'(1);  w_den = DW'(1); end
            MODE_4_3:    begin w_num = DW'(4);  w_den = DW'(3); end
            MODE_16_9:   begin w_num = DW'(16); w_den = DW'(9); end
            MODE_ORIG:   begin w_num = w_iw;    w_den = w_ih;   end
            default:     begin w_num = '0;      w_den = DW'(1); end
        endcase
    end

    // drag: order corners and clamp to the image
    logic signed [SW-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [SW-1:0] w_l, w_r, w_t, w_b, w_iws, w_ihs;
    logic signed [SW-1:0] w_lc, w_rc, w_tc, w_bc, w_dw, w_dh;

    always_comb begin
        w_ax  = SW'(i_corner_a_x);
        w_ay  = SW'(i_corner_a_y);
        w_bx  = SW'(i_corner_b_x);
        w_by  = SW'(i_corner_b_y);
        w_iws = signed'(SW'(w_iw));
        w_ihs = signed'(SW'(w_ih));
        w_l   = (w_ax < w_bx) ? w_ax : w_bx;
        w_r   = (w_ax < w_bx) ? w_bx : w_ax;
        w_t   = (w_ay < w_by) ? w_ay : w_by;
        w_b   = (w_ay < w_by) ? w_by : w_ay;
        w_lc  = (w_l < 0) ? SW'(0) : ((w_l > w_iws - SW'(1)) ? w_iws - SW'(1) : w_l);
        w_tc  = (w_t < 0) ? SW'(0) : ((w_t > w_ihs - SW'(1)) ? w_ihs - SW'(1) : w_t);
        w_rc  = (w_r < SW'(1)) ? SW'(1) : ((w_r > w_iws) ? w_iws : w_r);
        w_bc  = (w_b < SW'(1)) ? SW'(1) : ((w_b > w_ihs) ? w_ihs : w_b);
        w_dw  = w_rc - w_lc;
        w_dh  = w_bc - w_tc;
    end

    // sequencer
    t_state            r_state, n_state;
    logic [DW-1:0]     r_x, r_y, r_w, r_h, n_x, n_y, n_w, n_h;
    logic [DW-1:0]     r_num, r_den, n_num, n_den;
    logic [PW-1:0]     r_prod, n_prod;
    logic [DW-1:0]     r_sx, r_sy, r_sw, r_sh, n_sx, n_sy, n_sw, n_sh;
    logic              r_act, n_act;
    logic [OUT_XW-1:0] r_ox, r_oy, n_ox, n_oy;
    logic [OUT_WW-1:0] r_ow, r_oh, n_ow, n_oh;
    logic              r_oa, n_oa, r_ov, n_ov;

    logic              w_div_start;
    logic [NW-1:0]     w_dividend, w_quo;
    logic [DVW-1:0]    w_divisor;
    t_div_sts          w_div_sts;
    logic [DW-1:0]     w_mul_a, w_mul_b, w_dd, w_wc, w_hc, w_xlim, w_ylim;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_x = r_x;  n_y = r_y;  n_w = r_w;  n_h = r_h;
        n_num = r_num; n_den = r_den; n_prod = r_prod;
        n_sx = r_sx; n_sy = r_sy; n_sw = r_sw; n_sh = r_sh; n_act = r_act;
        n_ox = r_ox; n_oy = r_oy; n_ow = r_ow; n_oh = r_oh; n_oa = r_oa;
        n_ov        = r_ov && !i_out_ready;
        w_div_start = 1'b0;
        w_mul_a     = r_h;
        w_mul_b     = r_num;
        w_dd        = r_den;
        w_wc        = (r_w > w_iw) ? w_iw : r_w;
        w_hc        = (r_h > w_ih) ? w_ih : r_h;
        if (w_wc == '0) w_wc = DW'(1);
        if (w_hc == '0) w_hc = DW'(1);
        w_xlim      = w_iw - r_w;
        w_ylim      = w_ih - r_h;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACTION_DRAG) begin
                        n_x = w_lc[DW-1:0];
                        n_y = w_tc[DW-1:0];
                        n_w = w_dw[DW-1:0];
                        n_h = w_dh[DW-1:0];
                        n_state = S_FIT;
                    end else if (r_act) begin
                        n_x = r_sx; n_y = r_sy; n_w = r_sw; n_h = r_sh;
                        n_state = S_FIT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_FIT: begin
                n_num = w_num;
                n_den = w_den;
                if (w_num == '0 || r_h == '0) begin
                    n_state = S_CLAMP;
                end else begin
                    w_mul_b = w_num;
                    n_prod  = PW'(w_mul_a) * PW'(w_mul_b);
                    n_state = S_D1;
                end
            end
            S_D1: begin
                w_div_start = 1'b1;
                w_dd        = r_den;
                n_state     = S_D1W;
            end
            S_D1W: begin
                if (w_div_sts.done) begin
                    if (w_quo > NW'(w_iw)) begin
                        n_w     = w_iw;
                        w_mul_a = w_iw;
                        w_mul_b = r_den;
                        n_prod  = PW'(w_mul_a) * PW'(w_mul_b);
                        n_state = S_D2;
                    end else begin
                        n_w     = w_quo[DW-1:0];
                        n_state = S_CLAMP;
                    end
                end
            end
            S_D2: begin
                w_div_start = 1'b1;
                w_dd        = r_num;
                n_state     = S_D2W;
            end
            S_D2W: begin
                w_dd = r_num;
                if (w_div_sts.done) begin
                    n_h     = (w_quo > NW'(MAX_DIM)) ? DW'(MAX_DIM) : w_quo[DW-1:0];
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_w     = w_wc;
                n_h     = w_hc;
                n_state = S_ORG;
            end
            S_ORG: begin
                n_sx    = (r_x > w_xlim) ? w_xlim : r_x;
                n_sy    = (r_y > w_ylim) ? w_ylim : r_y;
                n_sw    = r_w;
                n_sh    = r_h;
                n_act   = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ox    = OUT_XW'(r_sx);
                    n_oy    = OUT_XW'(r_sy);
                    n_ow    = OUT_WW'(r_sw);
                    n_oh    = OUT_WW'(r_sh);
                    n_oa    = r_act;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_dividend = {r_prod, 1'b0} + NW'(w_dd);
    assign w_divisor  = {w_dd, 1'b0};

    cwaf_div #(
        .NW  (NW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_sts      (w_div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sw    <= '0;
            r_sh    <= '0;
            r_act   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_sw    <= n_sw;
            r_sh    <= n_sh;
            r_act   <= n_act;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_w    <= n_w;
        r_h    <= n_h;
        r_num  <= n_num;
        r_den  <= n_den;
        r_prod <= n_prod;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_ow   <= n_ow;
        r_oh   <= n_oh;
        r_oa   <= n_oa;
    end

    assign o_out_valid   = r_ov;
    assign o_rect_x      = r_ox;
    assign o_rect_y      = r_oy;
    assign o_rect_width  = r_ow;
    assign o_rect_height = r_oh;
    assign o_active      = r_oa;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_D1W || r_state == S_D2W))
        else $error("divider finished outside a wait state");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an input beat");

    a_active_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_sw != '0 && r_sh != '0))
        else $error("active rectangle with zero size");

endmodule
